FILE: rtl/fbsm_pkg.sv
`default_nettype none

package fbsm_pkg;

  typedef enum logic [2:0] {
    OP_START   = 3'd0,
    OP_ACQUIRE = 3'd1,
    OP_RELEASE = 3'd2,
    OP_LINE    = 3'd3,
    OP_RELOAD  = 3'd4
  } op_t;

  // Code 3 is unused and is never written.
  typedef enum logic [1:0] {
    ST_DRAW  = 2'd0,
    ST_READY = 2'd1,
    ST_SHOWN = 2'd2
  } bstate_t;

  typedef struct packed {
    logic [1:0] result_index;
    logic       found;
    logic       program_layers;
    logic       reload_immediate;
  } res_t;

endpackage

`default_nettype wire

FILE: rtl/fbsm_bank.sv
`default_nettype none

module fbsm_bank #(
  parameter int NUM_BUFFERS = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             go,
  input  fbsm_pkg::op_t    op,
  input  logic [1:0]       bidx,
  output fbsm_pkg::res_t   res
);
  import fbsm_pkg::*;

  localparam int IDX_W = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;

  bstate_t st_r   [NUM_BUFFERS];
  bstate_t st_nxt [NUM_BUFFERS];

  logic [IDX_W-1:0] draw_hit, ready_hit, live_hit;
  logic             draw_any, ready_any, live_any;
  logic             bidx_ok;

  function automatic logic [1:0] to_res(input logic [IDX_W-1:0] h);
    logic [IDX_W+1:0] e;
    e = {2'b00, h};
    return e[1:0];
  endfunction

  assign bidx_ok = (32'(bidx) < NUM_BUFFERS);

  // Priority encoders: scan downward so the lowest match wins.
  always_comb begin
    draw_hit  = '0;
    ready_hit = '0;
    live_hit  = '0;
    draw_any  = 1'b0;
    ready_any = 1'b0;
    live_any  = 1'b0;
    for (int i = NUM_BUFFERS - 1; i >= 0; i--) begin
      if (st_r[i] == ST_DRAW) begin
        draw_hit = IDX_W'(i);
        draw_any = 1'b1;
      end
      if (st_r[i] == ST_READY) begin
        ready_hit = IDX_W'(i);
        ready_any = 1'b1;
      end
      if (st_r[i] == ST_READY || st_r[i] == ST_SHOWN) begin
        live_hit = IDX_W'(i);
        live_any = 1'b1;
      end
    end
  end

  always_comb begin
    st_nxt = st_r;
    res    = '0;
    unique case (op)
      OP_START: begin
        for (int i = 0; i < NUM_BUFFERS; i++) begin
          st_nxt[i] = (live_any && IDX_W'(i) == live_hit) ? ST_SHOWN : ST_DRAW;
        end
        res.result_index     = live_any ? to_res(live_hit) : 2'd0;
        res.found            = 1'b1;
        res.program_layers   = 1'b1;
        res.reload_immediate = 1'b1;
      end
      OP_ACQUIRE: begin
        if (draw_any) begin
          res.result_index = to_res(draw_hit);
          res.found        = 1'b1;
        end
      end
      OP_RELEASE: begin
        for (int i = 0; i < NUM_BUFFERS; i++) begin
          if (bidx_ok && 32'(bidx) == i) st_nxt[i] = ST_READY;
        end
      end
      OP_LINE: begin
        if (ready_any) begin
          res.result_index   = to_res(ready_hit);
          res.found          = 1'b1;
          res.program_layers = 1'b1;
        end
      end
      OP_RELOAD: begin
        if (ready_any) begin
          for (int i = 0; i < NUM_BUFFERS; i++) begin
            if (IDX_W'(i) == ready_hit) st_nxt[i] = ST_SHOWN;
            else if (st_r[i] == ST_SHOWN) st_nxt[i] = ST_DRAW;
          end
          res.result_index = to_res(ready_hit);
          res.found        = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_BUFFERS; i++) st_r[i] <= ST_DRAW;
    end else if (go) begin
      st_r <= st_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/frame_buffer_swap_manager_top.sv
// Frame buffer swap manager: tracks draw / ready / displaying state for
// NUM_BUFFERS buffers and answers start, acquire, release, line and reload
// operations with exactly one result each. An operation is captured in an
// input register, evaluated combinationally against the buffer states and
// written to a result register, from which it is presented on the outputs;
// a stalled result side holds an operation in the input register. One
// operation can be taken every cycle while the result side is not stalled;
// the limit is the single read-modify-write of the buffer state table per
// cycle. Result indexes are reported on 2 bits.
`default_nettype none

module frame_buffer_swap_manager_top #(
  parameter int NUM_BUFFERS = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] in_opcode,
  input  logic [1:0] in_buffer_index,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_result_index,
  output logic       out_found,
  output logic       out_program_layers,
  output logic       out_reload_immediate
);
  import fbsm_pkg::*;

  logic       s1_valid_r;
  op_t        s1_op_r;
  logic [1:0] s1_bidx_r;
  logic       out_valid_r;
  res_t       out_r;
  res_t       res;
  logic       advance;
  logic       go;

  // Result register can load when empty or being drained this cycle.
  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !advance;
  assign go       = s1_valid_r && advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_op_r   <= op_t'(in_opcode);
      s1_bidx_r <= in_buffer_index;
    end
  end

  fbsm_bank #(
    .NUM_BUFFERS(NUM_BUFFERS)
  ) u_bank (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (go),
    .op    (s1_op_r),
    .bidx  (s1_bidx_r),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (go) out_r <= res;
  end

  assign out_valid            = out_valid_r;
  assign out_result_index     = out_r.result_index;
  assign out_found            = out_r.found;
  assign out_program_layers   = out_r.program_layers;
  assign out_reload_immediate = out_r.reload_immediate;

endmodule

`default_nettype wire

FILE: rtl/fbsm_checker.sv
`default_nettype none

module fbsm_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] out_result_index,
  input logic       out_found,
  input logic       out_program_layers,
  input logic       out_reload_immediate
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_result_index)
      && $stable(out_found) && $stable(out_program_layers)
      && $stable(out_reload_immediate))
    else $error("stalled result changed");

  a_start_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_reload_immediate |-> out_found && out_program_layers)
    else $error("start result without found/program");

  a_prog_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_program_layers |-> out_found)
    else $error("layer program without a buffer");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_result_index == 2'd0)
    else $error("miss with nonzero index");

endmodule

bind frame_buffer_swap_manager_top fbsm_checker u_fbsm_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .out_valid            (out_valid),
  .out_stall            (out_stall),
  .out_result_index     (out_result_index),
  .out_found            (out_found),
  .out_program_layers   (out_program_layers),
  .out_reload_immediate (out_reload_immediate)
);

`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import fbsm_pkg::*;

  localparam int NUM_BUF = 4;
  localparam logic [2:0] OP_UNDEF_FIRST = 3'd5;
  localparam logic [2:0] OP_UNDEF_LAST = 3'd7;
  localparam int QUIET_TAIL = 150;
  localparam int HOLD_CYCLES = 80;
  localparam int HOLD_AT = 300;

  typedef struct packed {
    logic [2:0] opcode;
    logic [1:0] index;
  } op_item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] in_opcode = '0;
  logic [1:0] in_buffer_index = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_result_index;
  logic out_found;
  logic out_program_layers;
  logic out_reload_immediate;

  op_item_t pending_ops[$];
  res_t exp_results[$];
  bstate_t buf_state[NUM_BUF];

  int errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_found = 0;
  int op_count[8];
  int send_gap = 0;
  int stall_left = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  frame_buffer_swap_manager_top #(.NUM_BUFFERS(NUM_BUF)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_opcode(in_opcode),
    .in_buffer_index(in_buffer_index),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_result_index(out_result_index),
    .out_found(out_found),
    .out_program_layers(out_program_layers),
    .out_reload_immediate(out_reload_immediate)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int lowest_in_state(bstate_t s);
    for (int i = 0; i < NUM_BUF; i++) begin
      if (buf_state[i] == s) return i;
    end
    return NUM_BUF;
  endfunction

  // Swap chain model: updates buf_state and returns the result of one transfer.
  function automatic res_t predict_swap(logic [2:0] op, logic [1:0] bidx);
    res_t r;
    int hit;
    r = '0;
    hit = NUM_BUF;
    case (op)
      OP_START: begin
        for (int i = 0; i < NUM_BUF; i++) begin
          if (hit == NUM_BUF && (buf_state[i] == ST_SHOWN || buf_state[i] == ST_READY)) begin
            hit = i;
            buf_state[i] = ST_SHOWN;
          end else begin
            buf_state[i] = ST_DRAW;
          end
        end
        // nothing to show: buffer 0 is reported but stays drawable
        r.result_index = (hit == NUM_BUF) ? 2'd0 : 2'(hit);
        r.found = 1'b1;
        r.program_layers = 1'b1;
        r.reload_immediate = 1'b1;
      end
      OP_ACQUIRE: begin
        hit = lowest_in_state(ST_DRAW);
        if (hit < NUM_BUF) begin
          r.result_index = 2'(hit);
          r.found = 1'b1;
        end
      end
      OP_RELEASE: begin
        if (int'(bidx) < NUM_BUF) buf_state[bidx] = ST_READY;
      end
      OP_LINE: begin
        hit = lowest_in_state(ST_READY);
        if (hit < NUM_BUF) begin
          r.result_index = 2'(hit);
          r.found = 1'b1;
          r.program_layers = 1'b1;
        end
      end
      OP_RELOAD: begin
        hit = lowest_in_state(ST_READY);
        if (hit < NUM_BUF) begin
          for (int i = 0; i < NUM_BUF; i++) begin
            if (buf_state[i] == ST_SHOWN) buf_state[i] = ST_DRAW;
          end
          buf_state[hit] = ST_SHOWN;
          r.result_index = 2'(hit);
          r.found = 1'b1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic add_op(logic [2:0] op, logic [1:0] idx);
    op_item_t it;
    it.opcode = op;
    it.index = idx;
    pending_ops.push_back(it);
  endtask

  // Sender
  always @(posedge clk) begin : drive_ops
    op_item_t it;
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= 0;
      for (int i = 0; i < NUM_BUF; i++) buf_state[i] = ST_DRAW;
    end else begin
      if (in_valid && !in_stall) begin
        exp_results.push_back(predict_swap(in_opcode, in_buffer_index));
        op_count[in_opcode]++;
        n_sent <= n_sent + 1;
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          in_valid <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (pending_ops.size() > 0) begin
          it = pending_ops.pop_front();
          in_valid <= 1'b1;
          in_opcode <= it.opcode;
          in_buffer_index <= it.index;
          if (pending_ops.size() >= QUIET_TAIL && $urandom_range(0, 9) == 0)
            send_gap <= $urandom_range(1, 14);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver back-pressure, with one long hold-off to fill the pipeline
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (!hold_done && n_sent >= HOLD_AT) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (pending_ops.size() >= QUIET_TAIL && $urandom_range(0, 7) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 13);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Monitor
  always @(posedge clk) begin : check_results
    res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (exp_results.size() == 0) begin
        $error("result transfer with no operation outstanding");
        errors++;
      end else begin
        want = exp_results.pop_front();
        n_checked++;
        if (out_found) n_found++;
        if (out_result_index !== want.result_index) begin
          $error("result_index: expected %0d, got %0d", want.result_index, out_result_index);
          errors++;
        end
        if (out_found !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, out_found);
          errors++;
        end
        if (out_program_layers !== want.program_layers) begin
          $error("program_layers: expected %0d, got %0d",
                 want.program_layers, out_program_layers);
          errors++;
        end
        if (out_reload_immediate !== want.reload_immediate) begin
          $error("reload_immediate: expected %0d, got %0d",
                 want.reload_immediate, out_reload_immediate);
          errors++;
        end
      end
    end
  end

  initial begin
    #1000000;
    $display("timeout waiting for results");
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int pick;
    for (int i = 0; i < 8; i++) op_count[i] = 0;

    // Directed: empty searches, start with nothing shown, promotion order,
    // no drawable buffer left, undefined opcodes.
    add_op(OP_ACQUIRE, 2'd3);
    add_op(OP_LINE, 2'd0);
    add_op(OP_RELOAD, 2'd3);
    add_op(OP_START, 2'd0);
    add_op(OP_RELEASE, 2'd3);
    add_op(OP_RELEASE, 2'd0);
    add_op(OP_LINE, 2'd1);
    add_op(OP_RELOAD, 2'd0);
    add_op(OP_ACQUIRE, 2'd0);
    add_op(OP_RELEASE, 2'd1);
    add_op(OP_RELEASE, 2'd2);
    add_op(OP_RELOAD, 2'd1);
    add_op(OP_ACQUIRE, 2'd2);
    add_op(OP_RELEASE, 2'd0);
    add_op(OP_ACQUIRE, 2'd3);
    add_op(OP_START, 2'd3);
    add_op(OP_LINE, 2'd2);
    for (logic [2:0] op = OP_UNDEF_FIRST; op <= OP_UNDEF_LAST && op >= OP_UNDEF_FIRST; op++)
      add_op(op, 2'd3);
    add_op(OP_RELEASE, 2'd3);
    add_op(OP_START, 2'd1);

    // Random traffic weighted toward the draw / release / swap cycle
    for (int n = 0; n < 1000; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 4) add_op(OP_START, 2'($urandom));
      else if (pick < 30) add_op(OP_ACQUIRE, 2'($urandom));
      else if (pick < 58) add_op(OP_RELEASE, 2'($urandom));
      else if (pick < 76) add_op(OP_LINE, 2'($urandom));
      else if (pick < 94) add_op(OP_RELOAD, 2'($urandom));
      else add_op(3'($urandom_range(OP_UNDEF_FIRST, OP_UNDEF_LAST)), 2'($urandom));
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_ops.size() > 0 || in_valid || exp_results.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (exp_results.size() != 0) begin
      $error("%0d results never arrived", exp_results.size());
      errors++;
    end

    $display("Ran %0d transfers: start %0d, acquire %0d, release %0d, line %0d, reload %0d,",
             n_sent, op_count[OP_START], op_count[OP_ACQUIRE], op_count[OP_RELEASE],
             op_count[OP_LINE], op_count[OP_RELOAD]);
    $display("undefined %0d; %0d results checked (%0d with a buffer found), %0d mismatches",
             op_count[5] + op_count[6] + op_count[7], n_checked, n_found, errors);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
